>>> src/pfe_pkg.sv
package pfe_pkg;

    localparam int SymW      = 8;
    localparam int CountW    = 16;
    localparam int ErrW      = 3;
    localparam int ValueOutW = 32;

    localparam logic [SymW-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SymW-1:0] CH_MINUS = 8'h2D;
    localparam logic [SymW-1:0] CH_STAR  = 8'h2A;
    localparam logic [SymW-1:0] CH_SLASH = 8'h2F;
    localparam logic [SymW-1:0] CH_PCT   = 8'h25;
    localparam logic [SymW-1:0] CH_ZERO  = 8'h30;
    localparam logic [SymW-1:0] CH_NINE  = 8'h39;

    localparam logic [CountW-1:0] OPS_MAX = 16'hFFFF;

    typedef enum logic [ErrW-1:0] {
        ERR_NONE    = 3'd0,
        ERR_DIV0    = 3'd1,
        ERR_UNDER   = 3'd2,
        ERR_OVER    = 3'd3,
        ERR_UNKNOWN = 3'd4
    } t_err;

    typedef struct packed {
        logic take;
        logic push;
        logic flag;
        t_err flag_code;
        logic fast;
        logic start;
        logic step;
        logic apply;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_digit;
        logic is_op;
        logic is_fast;
        logic is_div;
        logic full;
        logic lt2;
        logic right_zero;
        logic iter_last;
        logic end_mark;
    } t_dp_status;

endpackage

>>> src/pfe_in_if.sv
interface pfe_in_if import pfe_pkg::*;;
    logic            valid;
    logic            ready;
    logic [SymW-1:0] symbol;
    logic            end_of_expression;

    modport source (output valid, output symbol, output end_of_expression, input ready);
    modport sink (input valid, input symbol, input end_of_expression, output ready);
endinterface

>>> src/pfe_out_if.sv
interface pfe_out_if import pfe_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic signed [ValueOutW-1:0] value;
    logic [CountW-1:0]           operator_count;
    logic [ErrW-1:0]             error_code;

    modport source (output valid, output value, output operator_count, output error_code,
                    input ready);
    modport sink (input valid, input value, input operator_count, input error_code,
                  output ready);
endinterface

>>> src/pfe_ram.sv
module pfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/pfe_ctrl.sv
module pfe_ctrl import pfe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_ITER,
        S_APPLY,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.flag_code = ERR_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                priority if (i_status.is_digit) begin
                    if (i_status.full) begin
                        o_cmd.flag      = 1'b1;
                        o_cmd.flag_code = ERR_OVER;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                end else if (i_status.is_op) begin
                    if (i_status.lt2) begin
                        o_cmd.flag      = 1'b1;
                        o_cmd.flag_code = ERR_UNDER;
                    end else begin
                        n_state = S_LOAD;
                    end
                end else begin
                    o_cmd.flag      = 1'b1;
                    o_cmd.flag_code = ERR_UNKNOWN;
                end
            end
            S_LOAD: begin
                // left operand is now out of the stack ram
                priority if (i_status.is_fast) begin
                    o_cmd.fast = 1'b1;
                    n_state    = S_FINISH;
                end else if (i_status.is_div && i_status.right_zero) begin
                    o_cmd.fast      = 1'b1;
                    o_cmd.flag      = 1'b1;
                    o_cmd.flag_code = ERR_DIV0;
                    n_state         = S_FINISH;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = S_ITER;
                end
            end
            S_ITER: begin
                o_cmd.step = 1'b1;
                if (i_status.iter_last) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                if (!i_status.end_mark) begin
                    n_state = S_IDLE;
                end else if (slot_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> src/pfe_dp.sv
module pfe_dp import pfe_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd,
    output t_dp_status                  o_status,
    input  logic [SymW-1:0]             i_symbol,
    input  logic                        i_end,
    output logic signed [ValueOutW-1:0] o_value,
    output logic [CountW-1:0]           o_count,
    output logic [ErrW-1:0]             o_err
);

    localparam int W    = VALUE_WIDTH;
    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int SpW  = $clog2(STACK_DEPTH + 1);
    localparam int CntW = $clog2(VALUE_WIDTH);

    // item and stack control
    logic [SymW-1:0]   r_sym;
    logic              r_end;
    logic [SpW-1:0]    r_sp, n_sp;
    logic [CountW-1:0] r_ops, n_ops;
    t_err              r_err, n_err;
    logic signed [W-1:0] r_top, n_top;

    // shared shift-add / restoring divide unit
    logic [W-1:0]    r_a, n_a;
    logic [W-1:0]    r_b, n_b;
    logic [W-1:0]    r_acc, n_acc;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_neg_q, n_neg_q;
    logic            r_neg_r, n_neg_r;

    logic signed [ValueOutW-1:0] r_out_value;
    logic [CountW-1:0]           r_out_count;
    t_err                        r_out_err;

    logic [W-1:0] ram_rdata;
    logic [W-1:0] left;
    logic [W-1:0] right;
    logic         is_mul;
    logic         sp_zero;
    logic [W-1:0] fast_res;
    logic [W-1:0] iter_res;
    logic [W-1:0] rem_sh;
    logic [W:0]   diff;
    logic [W-1:0] digit;
    logic [SpW-1:0] sp_m1;
    logic [SpW-1:0] sp_m2;

    assign left    = ram_rdata;
    assign right   = r_top;
    assign is_mul  = (r_sym == CH_STAR);
    assign sp_zero = (r_sp == '0);
    assign sp_m1   = r_sp - SpW'(1);
    assign sp_m2   = r_sp - SpW'(2);
    assign digit   = W'(r_sym - CH_ZERO);

    pfe_ram #(
        .WIDTH(W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (i_cmd.push && !sp_zero),
        .i_waddr(sp_m1[AW-1:0]),
        .i_wdata(r_top),
        .i_raddr(sp_m2[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        o_status.is_digit   = (r_sym >= CH_ZERO) && (r_sym <= CH_NINE);
        o_status.is_fast    = (r_sym == CH_PLUS) || (r_sym == CH_MINUS);
        o_status.is_div     = (r_sym == CH_SLASH) || (r_sym == CH_PCT);
        o_status.is_op      = o_status.is_fast || o_status.is_div || is_mul;
        o_status.full       = (r_sp == SpW'(STACK_DEPTH));
        o_status.lt2        = (r_sp < SpW'(2));
        o_status.right_zero = (r_top == '0);
        o_status.iter_last  = (r_cnt == CntW'(W - 1));
        o_status.end_mark   = r_end;
    end

    always_comb begin
        priority if (r_sym == CH_PLUS) begin
            fast_res = left + right;
        end else if (r_sym == CH_MINUS) begin
            fast_res = left - right;
        end else begin
            fast_res = '0;  // divisor zero
        end
    end

    always_comb begin
        priority if (is_mul) begin
            iter_res = r_acc;
        end else if (r_sym == CH_SLASH) begin
            iter_res = r_neg_q ? ('0 - r_a) : r_a;
        end else begin
            iter_res = r_neg_r ? ('0 - r_acc) : r_acc;
        end
    end

    assign rem_sh = {r_acc[W-2:0], r_a[W-1]};
    assign diff   = {1'b0, rem_sh} - {1'b0, r_b};

    always_comb begin
        n_sp    = r_sp;
        n_ops   = r_ops;
        n_err   = r_err;
        n_top   = r_top;
        n_a     = r_a;
        n_b     = r_b;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_neg_q = r_neg_q;
        n_neg_r = r_neg_r;

        if (i_cmd.flag && (r_err == ERR_NONE)) begin
            n_err = i_cmd.flag_code;
        end
        if (i_cmd.push) begin
            n_top = digit;
            n_sp  = r_sp + SpW'(1);
        end
        if (i_cmd.fast || i_cmd.apply) begin
            n_top = i_cmd.fast ? fast_res : iter_res;
            n_sp  = sp_m1;
            if (r_ops != OPS_MAX) begin
                n_ops = r_ops + CountW'(1);
            end
        end
        if (i_cmd.start) begin
            n_acc   = '0;
            n_cnt   = '0;
            n_neg_q = left[W-1] ^ right[W-1];
            n_neg_r = left[W-1];
            if (is_mul) begin
                n_a = left;
                n_b = right;
            end else begin
                n_a = left[W-1] ? ('0 - left) : left;
                n_b = right[W-1] ? ('0 - right) : right;
            end
        end
        if (i_cmd.step) begin
            n_cnt = r_cnt + CntW'(1);
            if (is_mul) begin
                if (r_b[0]) begin
                    n_acc = r_acc + r_a;
                end
                n_a = {r_a[W-2:0], 1'b0};
                n_b = {1'b0, r_b[W-1:1]};
            end else begin
                // restoring step, quotient bits shift into r_a
                n_acc = diff[W] ? rem_sh : diff[W-1:0];
                n_a   = {r_a[W-2:0], !diff[W]};
            end
        end
        if (i_cmd.emit) begin
            n_sp  = '0;
            n_ops = '0;
            n_err = ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp  <= '0;
            r_ops <= '0;
            r_err <= ERR_NONE;
        end else begin
            r_sp  <= n_sp;
            r_ops <= n_ops;
            r_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sym <= i_symbol;
            r_end <= i_end;
        end
        r_top   <= n_top;
        r_a     <= n_a;
        r_b     <= n_b;
        r_acc   <= n_acc;
        r_cnt   <= n_cnt;
        r_neg_q <= n_neg_q;
        r_neg_r <= n_neg_r;
        if (i_cmd.emit) begin
            r_out_value <= sp_zero ? '0 : ValueOutW'(r_top);
            r_out_count <= r_ops;
            r_out_err   <= ((r_err == ERR_NONE) && sp_zero) ? ERR_UNDER : r_err;
        end
    end

    assign o_value = r_out_value;
    assign o_count = r_out_count;
    assign o_err   = r_out_err;

endmodule

>>> src/postfix_expression_evaluator_core.sv
// Postfix evaluator: one ASCII symbol per request; digits push 0..9, + - * / % pop two values
// and push the wrapped signed result, and a request with end_of_expression set produces one
// result (top value, operator count, first error) and clears the evaluator. A digit, an
// unknown symbol or an operator that finds fewer than two values goes from decode to finish;
// + and - add a load step; * / % add a load step, the iterations of the one-bit-per-cycle
// shift-add multiplier and restoring divider, and an apply step; / and % with a zero divisor
// skip the divider. The last symbol of an expression may take longer while the previous
// result is still waiting on the output; other requests are taken while a result waits.
module postfix_expression_evaluator_core import pfe_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pfe_in_if.sink          i_in,
    pfe_out_if.source       o_out
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;
    logic       out_valid;

    pfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .o_out_valid(out_valid),
        .i_out_ready(o_out.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pfe_dp #(
        .STACK_DEPTH(STACK_DEPTH),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_status(status),
        .i_symbol(i_in.symbol),
        .i_end   (i_in.end_of_expression),
        .o_value (o_out.value),
        .o_count (o_out.operator_count),
        .o_err   (o_out.error_code)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

>>> src/pfe_checker.sv
module pfe_checker import pfe_pkg::*; (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic signed [ValueOutW-1:0] i_value,
    input logic [CountW-1:0]           i_count,
    input logic [ErrW-1:0]             i_err
);

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_value) && $stable(i_count) && $stable(i_err))
        else $error("result changed while stalled");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_err <= ERR_UNKNOWN))
        else $error("error code out of range");

    // ready is low in the cycle after every accepted symbol
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while busy");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("not idle after reset");

endmodule

bind postfix_expression_evaluator_core pfe_checker u_pfe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_value    (o_out.value),
    .i_count    (o_out.operator_count),
    .i_err      (o_out.error_code)
);

>>> tb/pfe_eval_checker.sv
module pfe_eval_checker import pfe_pkg::*; #(
    parameter int STACK_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pfe_in_if    i_sym,
    pfe_out_if   i_res,
    output int   o_mismatches,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [ValueOutW-1:0] value;
        logic [CountW-1:0]           count;
        t_err                        err;
    } t_eval_result;

    logic signed [ValueOutW-1:0] eval_stack [STACK_DEPTH];
    int unsigned                 depth;
    logic [CountW-1:0]           ops_applied;
    t_err                        first_err;
    t_eval_result                expr_answers [$];
    int                          fail_count;

    function automatic void clear_eval();
        depth       = 0;
        ops_applied = '0;
        first_err   = ERR_NONE;
    endfunction

    // only the first error of an expression is kept
    function automatic void raise_err(t_err code);
        if (first_err == ERR_NONE) begin
            first_err = code;
        end
    endfunction

    function automatic logic signed [ValueOutW-1:0] apply_op(
        input logic [SymW-1:0]           op,
        input logic signed [ValueOutW-1:0] lhs,
        input logic signed [ValueOutW-1:0] rhs
    );
        logic signed [ValueOutW-1:0] most_neg;
        most_neg = {1'b1, {(ValueOutW-1){1'b0}}};
        case (op)
            CH_PLUS:  return lhs + rhs;
            CH_MINUS: return lhs - rhs;
            CH_STAR:  return lhs * rhs;
            default: begin
                if (rhs == 0) begin
                    raise_err(ERR_DIV0);
                    return '0;
                end
                // quotient wraps, remainder is zero
                if (lhs == most_neg && rhs == -1) begin
                    return (op == CH_PCT) ? '0 : most_neg;
                end
                return (op == CH_PCT) ? lhs % rhs : lhs / rhs;
            end
        endcase
    endfunction

    // returns 1 when the symbol closes an expression and fills in its result
    function automatic bit eval_symbol(
        input  logic [SymW-1:0] sym,
        input  logic            last,
        output t_eval_result    res
    );
        logic signed [ValueOutW-1:0] lhs;
        logic signed [ValueOutW-1:0] rhs;
        res = '0;
        if (sym >= CH_ZERO && sym <= CH_NINE) begin
            if (depth >= STACK_DEPTH) begin
                raise_err(ERR_OVER);
            end else begin
                eval_stack[depth] = ValueOutW'(sym - CH_ZERO);
                depth++;
            end
        end else if (sym inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT}) begin
            if (depth < 2) begin
                raise_err(ERR_UNDER);
            end else begin
                rhs   = eval_stack[depth-1];
                lhs   = eval_stack[depth-2];
                depth = depth - 2;
                eval_stack[depth] = apply_op(sym, lhs, rhs);
                depth++;
                if (ops_applied != OPS_MAX) begin
                    ops_applied++;
                end
            end
        end else begin
            raise_err(ERR_UNKNOWN);
        end
        if (!last) begin
            return 1'b0;
        end
        if (depth == 0) begin
            raise_err(ERR_UNDER);
        end else begin
            res.value = eval_stack[depth-1];
        end
        res.count = ops_applied;
        res.err   = first_err;
        clear_eval();
        return 1'b1;
    endfunction

    initial begin
        clear_eval();
        fail_count = 0;
    end

    always @(posedge i_clk) begin
        t_eval_result want;
        t_eval_result closed;
        if (!i_rst_n) begin
            clear_eval();
            expr_answers.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expr_answers.size() == 0) begin
                    $display("%0t: result with nothing expected, actual value %0d count %0d error %0d",
                             $time, i_res.value, i_res.operator_count, i_res.error_code);
                    fail_count++;
                end else begin
                    want = expr_answers.pop_front();
                    if (i_res.value !== want.value) begin
                        $display("%0t: value mismatch, expected %0d, actual %0d",
                                 $time, want.value, i_res.value);
                        fail_count++;
                    end
                    if (i_res.operator_count !== want.count) begin
                        $display("%0t: operator count mismatch, expected %0d, actual %0d",
                                 $time, want.count, i_res.operator_count);
                        fail_count++;
                    end
                    if (i_res.error_code !== want.err) begin
                        $display("%0t: error code mismatch, expected %0d, actual %0d",
                                 $time, want.err, i_res.error_code);
                        fail_count++;
                    end
                end
            end
            if (i_sym.valid && i_sym.ready) begin
                if (eval_symbol(i_sym.symbol, i_sym.end_of_expression, closed)) begin
                    expr_answers.push_back(closed);
                end
            end
        end
        o_mismatches <= fail_count;
        o_pending    <= expr_answers.size();
    end

endmodule

>>> tb/tb_top.sv
module tb_top import pfe_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 16;
    localparam int TARGET_ITEMS = 1900;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [SymW-1:0] SYM_JUNK = 8'hFF;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   idle_en;
    int   items_sent;
    int   mismatches;
    int   pending;
    logic [SymW-1:0] expr_buf [$];

    pfe_in_if  sym_ch ();
    pfe_out_if res_ch ();

    postfix_expression_evaluator_core #(
        .STACK_DEPTH (DEPTH),
        .VALUE_WIDTH (ValueOutW)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sym_ch),
        .o_out   (res_ch)
    );

    pfe_eval_checker #(
        .STACK_DEPTH (DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sym        (sym_ch),
        .i_res        (res_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #5ns i_clk = ~i_clk;

    task automatic send_symbol(input logic [SymW-1:0] sym, input logic last);
        int gap;
        gap = idle_en ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            sym_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sym_ch.valid             <= 1'b1;
        sym_ch.symbol            <= sym;
        sym_ch.end_of_expression <= last;
        do @(posedge i_clk); while (!sym_ch.ready);
        items_sent++;
    endtask

    task automatic send_expr();
        foreach (expr_buf[i]) begin
            send_symbol(expr_buf[i], i == expr_buf.size() - 1);
        end
        expr_buf.delete();
    endtask

    function automatic void push_digit(input int d);
        expr_buf.push_back(CH_ZERO + SymW'(d));
    endfunction

    function automatic void push_op(input logic [SymW-1:0] op);
        expr_buf.push_back(op);
    endfunction

    function automatic logic [SymW-1:0] pick_operator();
        case ($urandom_range(0, 4))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            default: return CH_PCT;
        endcase
    endfunction

    // mostly valid postfix with random content, now and then a stray byte or values left over
    function automatic void build_wellformed();
        int  target;
        int  d;
        bit  leave_extra;
        target      = $urandom_range(1, 24);
        d           = 0;
        leave_extra = ($urandom_range(0, 7) == 0);
        for (int n = 0; n < target; n++) begin
            if ($urandom_range(0, 31) == 0) begin
                expr_buf.push_back(SymW'($urandom_range(0, 255)));
            end else if (d < 2 || (d < DEPTH && $urandom_range(0, 1) == 1)) begin
                push_digit($urandom_range(0, 9));
                d++;
            end else begin
                push_op(pick_operator());
                d--;
            end
        end
        while (d > 1 && !leave_extra) begin
            push_op(pick_operator());
            d--;
        end
    endfunction

    // builds the most negative value, then divides it or takes its remainder, mostly by -1
    function automatic void build_most_neg();
        if ($urandom_range(0, 1) == 1) begin
            push_digit(0);
            push_digit(8);
            push_op(CH_MINUS);
        end else begin
            push_digit(8);
        end
        repeat (9) begin
            push_digit(8);
            push_op(CH_STAR);
        end
        push_digit(2);
        push_op(CH_STAR);
        if ($urandom_range(0, 3) < 3) begin
            push_digit(0);
            push_digit(1);
            push_op(CH_MINUS);
        end else begin
            push_digit($urandom_range(0, 9));
        end
        push_op($urandom_range(0, 1) ? CH_SLASH : CH_PCT);
    endfunction

    function automatic void build_overflow();
        repeat ($urandom_range(DEPTH + 1, DEPTH + 4)) push_digit($urandom_range(0, 9));
        repeat ($urandom_range(0, DEPTH)) push_op(pick_operator());
    endfunction

    function automatic void build_noise();
        repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 1) == 1) begin
                expr_buf.push_back(SymW'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 1) == 1) begin
                push_digit($urandom_range(0, 9));
            end else begin
                push_op(pick_operator());
            end
        end
    endfunction

    task automatic run_directed();
        // sign of remainder follows the dividend
        push_digit(0); push_digit(7); push_op(CH_MINUS); push_digit(3); push_op(CH_PCT);
        send_expr();
        // truncation toward zero
        push_digit(0); push_digit(7); push_op(CH_MINUS); push_digit(2); push_op(CH_SLASH);
        send_expr();
        push_digit(9); push_digit(8); push_op(CH_STAR);
        send_expr();
        // operator with one value on the stack
        push_digit(9); push_op(CH_PLUS);
        send_expr();
        push_digit(5); push_digit(0); push_op(CH_PCT);
        send_expr();
        // unknown symbol alone, stack empty at the end
        expr_buf.push_back(SYM_JUNK);
        send_expr();
        // two values left, top one given
        push_digit(1); push_digit(2); push_digit(3); push_op(CH_PLUS);
        send_expr();
        // underflow first, then divide by zero, first error kept
        push_op(CH_PLUS); push_digit(0); push_digit(0); push_op(CH_SLASH);
        send_expr();
    endtask

    // result side
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = idle_en ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    // watchdog on cycles without any accepted request or result
    initial begin
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1 || (sym_ch.valid && sym_ch.ready) ||
                (res_ch.valid && res_ch.ready)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        int pick;
        idle_en    = 1'b1;
        items_sent = 0;
        i_rst_n                  <= 1'b0;
        sym_ch.valid             <= 1'b0;
        sym_ch.symbol            <= '0;
        sym_ch.end_of_expression <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        while (items_sent < TARGET_ITEMS) begin
            idle_en = ($urandom_range(0, 7) != 0);
            pick    = $urandom_range(0, 99);
            if (pick < 70) begin
                build_wellformed();
            end else if (pick < 76) begin
                build_most_neg();
            end else if (pick < 82) begin
                build_overflow();
            end else begin
                build_noise();
            end
            send_expr();
        end

        idle_en = 1'b0;
        sym_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
